// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL; nnpm_ctrl includes them.
// Checks are compiled out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hdl/nnpm_pkg.sv =====
// ----------------------------------------------------------------------------
// nnpm_pkg
// Shared constants, codes and types of the nearest point matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package nnpm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIV_STEPS  = 49;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_FIRST_X_LOW   = 3'd0,
        REG_FIRST_X_SPAN  = 3'd1,
        REG_FIRST_Y_LOW   = 3'd2,
        REG_FIRST_Y_SPAN  = 3'd3,
        REG_SECOND_X_LOW  = 3'd4,
        REG_SECOND_X_SPAN = 3'd5,
        REG_SECOND_Y_LOW  = 3'd6,
        REG_SECOND_Y_SPAN = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [15:0]        point_label;
        logic               label_given;
        logic [15:0]        query_tag;
    } in_item_t;

    typedef struct packed {
        logic [15:0] reply_tag;
        logic        match_found;
        logic [15:0] match_label;
        logic        match_labelled;
        logic        store_full;
        logic [63:0] best_distance_sq;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_y;
        logic take_x;
        logic take_y;
        logic decide;
        logic issue;
        logic res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode;
        logic div_done;
        logic empty;
        logic issue_last;
        logic pipe_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/nnpm_channels.sv =====
// ----------------------------------------------------------------------------
// nnpm channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnpm_item_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [15:0]        point_label;
    logic               label_given;
    logic [15:0]        query_tag;

    modport source (output valid, mode, coord_x, coord_y, point_label, label_given,
                    query_tag, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, point_label, label_given,
                    query_tag, output ready);
endinterface

interface nnpm_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] reply_tag;
    logic        match_found;
    logic [15:0] match_label;
    logic        match_labelled;
    logic        store_full;
    logic [63:0] best_distance_sq;

    modport source (output valid, reply_tag, match_found, match_label, match_labelled,
                    store_full, best_distance_sq, input ready);
    modport sink   (input valid, reply_tag, match_found, match_label, match_labelled,
                    store_full, best_distance_sq, output ready);
endinterface

`default_nettype wire

// ===== hdl/normalized_nearest_point_match_core.sv =====
// ----------------------------------------------------------------------------
// normalized_nearest_point_match_core
// Nearest stored point search over box-normalized Q16.16 coordinates.
// ----------------------------------------------------------------------------
// One item at a time. Both coordinates go through one shared restoring
// divider of 49 steps each; a load, or a query on an empty store, then goes
// straight to its result. A query on N stored points then scans the store at
// one point per cycle from a single memory read port, plus a four-stage
// pipeline drain. The store needs no clearing pass; a new item is taken while
// the previous result waits.
`default_nettype none

module normalized_nearest_point_match_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    nnpm_item_if.sink         item,
    nnpm_result_if.source     result
);

    nnpm_pkg::in_item_t  item_in;
    nnpm_pkg::out_item_t res;
    nnpm_pkg::ctrl_cmd_t cmd;
    nnpm_pkg::dp_stat_t  stat;

    always_comb
    begin
        item_in.mode        = item.mode;
        item_in.coord_x     = item.coord_x;
        item_in.coord_y     = item.coord_y;
        item_in.point_label = item.point_label;
        item_in.label_given = item.label_given;
        item_in.query_tag   = item.query_tag;
    end

    nnpm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    nnpm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_in    (item_in),
        .cmd        (cmd),
        .stat       (stat),
        .result_out (res)
    );

    assign result.reply_tag        = res.reply_tag;
    assign result.match_found      = res.match_found;
    assign result.match_label      = res.match_label;
    assign result.match_labelled   = res.match_labelled;
    assign result.store_full       = res.store_full;
    assign result.best_distance_sq = res.best_distance_sq;

endmodule

`default_nettype wire

// ===== hdl/nnpm_div.sv =====
// ----------------------------------------------------------------------------
// nnpm_div
// Restoring divider, one quotient bit per cycle, signed saturating result.
// ----------------------------------------------------------------------------
`default_nettype none

module nnpm_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [48:0] dividend,
    input  wire logic        negative,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [30:0]                    rem_reg, rem_next;
    logic [48:0]                    quo_reg, quo_next;
    logic [30:0]                    dsr_reg;
    logic                           neg_reg;
    logic [nnpm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [31:0]                    trial;
    logic                           ge;
    logic                           sat;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[48]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (cnt_reg != '0)
        begin
            // The remainder stays below the divisor, so 31 bits hold it.
            rem_next  = ge ? 31'(trial - {1'b0, dsr_reg}) : trial[30:0];
            quo_next  = {quo_reg[47:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == nnpm_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= nnpm_pkg::DIV_CNT_W'(nnpm_pkg::DIV_STEPS);
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= (divisor == '0) ? 31'd1 : divisor;
            neg_reg <= negative;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Clamp to the signed 32-bit range, truncation toward zero.
    always_comb
    begin
        if (neg_reg)
        begin
            sat      = (|quo_reg[48:32]) || (quo_reg[31] && (|quo_reg[30:0]));
            quotient = sat ? 32'h8000_0000 : (32'd0 - quo_reg[31:0]);
        end
        else
        begin
            sat      = |quo_reg[48:31];
            quotient = sat ? 32'h7FFF_FFFF : {1'b0, quo_reg[30:0]};
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/nnpm_datapath.sv =====
// ----------------------------------------------------------------------------
// nnpm_datapath
// Box registers, normalization, point store and the pipelined distance scan.
// ----------------------------------------------------------------------------
`default_nettype none

module nnpm_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire nnpm_pkg::in_item_t   item_in,
    input  wire nnpm_pkg::ctrl_cmd_t  cmd,
    output nnpm_pkg::dp_stat_t        stat,
    output nnpm_pkg::out_item_t       result_out
);

    localparam int ADDR_W = nnpm_pkg::ADDR_W;
    localparam int CNT_W  = nnpm_pkg::CNT_W;

    logic signed [31:0] low_reg  [4];
    logic [30:0]        span_reg [4];

    nnpm_pkg::in_item_t item_reg;
    logic [31:0]        qx_reg, qy_reg;

    logic [1:0]         box;
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic               div_done;
    logic [31:0]        div_q;

    logic [80:0]        mem [nnpm_pkg::MAX_POINTS];
    logic [80:0]        rd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   addr_reg;
    logic               full;
    logic               full_flag_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic [16:0]        lab2_reg, lab3_reg;
    logic [63:0]        sqx_reg, sqy_reg;
    logic signed [32:0] dx, dy;
    logic [64:0]        sum;
    logic [63:0]        cand_dist;

    logic               found_reg;
    logic [63:0]        best_reg;
    logic [16:0]        best_lab_reg;
    nnpm_pkg::out_item_t res_reg, res_next;

    // Box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                low_reg[i]  <= '0;
                span_reg[i] <= 31'd1;
            end
        end
        else if (cfg_we)
        begin
            unique case (nnpm_pkg::reg_idx_t'(cfg_index))
                nnpm_pkg::REG_FIRST_X_LOW:   low_reg[0]  <= cfg_data;
                nnpm_pkg::REG_FIRST_X_SPAN:  span_reg[0] <= cfg_data[30:0];
                nnpm_pkg::REG_FIRST_Y_LOW:   low_reg[1]  <= cfg_data;
                nnpm_pkg::REG_FIRST_Y_SPAN:  span_reg[1] <= cfg_data[30:0];
                nnpm_pkg::REG_SECOND_X_LOW:  low_reg[2]  <= cfg_data;
                nnpm_pkg::REG_SECOND_X_SPAN: span_reg[2] <= cfg_data[30:0];
                nnpm_pkg::REG_SECOND_Y_LOW:  low_reg[3]  <= cfg_data;
                nnpm_pkg::REG_SECOND_Y_SPAN: span_reg[3] <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item_in;
        if (cmd.take_x)
            qx_reg <= div_q;
        if (cmd.take_y)
            qy_reg <= div_q;
    end

    // Queries use the first box, loads the second.
    always_comb
    begin
        box  = {item_reg.mode == nnpm_pkg::MODE_LOAD, cmd.div_y};
        diff = (cmd.div_y ? 33'(item_reg.coord_y) : 33'(item_reg.coord_x))
             - 33'(low_reg[box]);
        mag  = diff[32] ? (33'd0 - diff) : diff;
    end

    nnpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({mag, 16'd0}),
        .negative (diff[32]),
        .divisor  (span_reg[box]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign full = (count_reg == CNT_W'(nnpm_pkg::MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (cmd.decide && item_reg.mode == nnpm_pkg::MODE_LOAD && !full)
            mem[count_reg[ADDR_W-1:0]] <= {item_reg.label_given,
                                           item_reg.label_given ? item_reg.point_label
                                                                : 16'd0,
                                           qy_reg, qx_reg};
        if (cmd.issue)
            rd_reg <= mem[addr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            addr_reg      <= '0;
            full_flag_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.decide)
            begin
                addr_reg      <= '0;
                found_reg     <= 1'b0;
                full_flag_reg <= full;
                if (item_reg.mode == nnpm_pkg::MODE_LOAD && !full)
                    count_reg <= count_reg + 1'b1;
            end
            else if (cmd.issue)
                addr_reg <= addr_reg + 1'b1;
            if (v3_reg)
                found_reg <= 1'b1;
        end
    end

    // Scan pipeline: read, difference, square, accumulate minimum.
    always_comb
    begin
        dx        = 33'($signed(qx_reg)) - 33'($signed(rd_reg[31:0]));
        dy        = 33'($signed(qy_reg)) - 33'($signed(rd_reg[63:32]));
        sum       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        cand_dist = sum[64] ? '1 : sum[63:0];
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        ay_reg   <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
        lab2_reg <= rd_reg[80:64];
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        lab3_reg <= lab2_reg;
        // Strictly nearer only: ties keep the earliest load.
        if (v3_reg && (!found_reg || cand_dist < best_reg))
        begin
            best_reg     <= cand_dist;
            best_lab_reg <= lab3_reg;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (item_reg.mode == nnpm_pkg::MODE_LOAD)
            res_next.store_full = full_flag_reg;
        else
        begin
            res_next.reply_tag = item_reg.query_tag;
            if (found_reg)
            begin
                res_next.match_found      = 1'b1;
                res_next.match_labelled   = best_lab_reg[16];
                res_next.match_label      = best_lab_reg[16] ? best_lab_reg[15:0] : 16'd0;
                res_next.best_distance_sq = best_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
            res_reg <= res_next;
    end

    always_comb
    begin
        stat.mode       = item_reg.mode;
        stat.div_done   = div_done;
        stat.empty      = (count_reg == '0);
        stat.issue_last = (addr_reg == count_reg - 1'b1);
        stat.pipe_busy  = v1_reg | v2_reg | v3_reg;
    end

    assign result_out = res_reg;

endmodule

`default_nettype wire

// ===== hdl/nnpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// nnpm_ctrl
// Sequencer: normalize, store or scan, then hand the result beat out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nnpm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    output logic                     res_valid,
    input  wire logic                res_ready,
    input  wire nnpm_pkg::dp_stat_t  stat,
    output nnpm_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_X_GO, S_X_WAIT, S_Y_GO, S_Y_WAIT, S_DECIDE, S_SCAN, S_DRAIN, S_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res_ready;
        item_ready     = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = item_valid;
                if (item_valid)
                    state_next = S_X_GO;
            end
            S_X_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_X_WAIT;
            end
            S_X_WAIT:
            begin
                cmd.take_x = stat.div_done;
                if (stat.div_done)
                    state_next = S_Y_GO;
            end
            S_Y_GO:
            begin
                cmd.div_y     = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_Y_WAIT;
            end
            S_Y_WAIT:
            begin
                cmd.take_y = stat.div_done;
                if (stat.div_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.mode == nnpm_pkg::MODE_QUERY && !stat.empty)
                    state_next = S_SCAN;
                else
                    state_next = S_REPLY;
            end
            S_SCAN:
            begin
                // Issue one read per cycle up to the last stored point.
                cmd.issue = 1'b1;
                if (stat.issue_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // Hold until the last distance has reached the running minimum.
                if (!stat.pipe_busy)
                    state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;

    `ASSERT_CLK(a_load_slot_free, cmd.res_load |-> (!out_valid_reg || res_ready),
                "result overwritten")
    `ASSERT_CLK(a_div_done_waiting,
                stat.div_done |-> (state_reg == S_X_WAIT || state_reg == S_Y_WAIT),
                "stray divider done")
    `ASSERT_NEVER(a_issue_outside_scan, cmd.issue && state_reg != S_SCAN,
                  "read issued outside scan")
    `ASSERT_CLK(a_reply_after_load, cmd.res_load |=> (res_valid && state_reg == S_IDLE),
                "result not presented")

endmodule

`default_nettype wire
